// ===== rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// Used by ffa_ctrl, ffa_dp and first_fit_block_allocator_unit; no dependencies.
package ffa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 64;

  localparam logic [31:0] REGION_BASE_RST  = 32'h6000_0000;
  localparam logic [31:0] REGION_BYTES_RST = 32'h3000_0000;
  localparam logic [7:0]  HEADER_BYTES_RST = 8'd24;

  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [1:0] REG_REGION_BYTES = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_NO_FIT   = 2'd1,
    OUT_BAD_ADDR = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    outcome_e    outcome;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP,
    OP_READ_HEAD,
    OP_NEXT,
    OP_MARK_USED,
    OP_SCAN_START,
    OP_SCAN_INC,
    OP_SPLIT_NEW,
    OP_SPLIT_CUR,
    OP_RESULT,
    OP_MARK_FREE,
    OP_C_LOAD,
    OP_C_FETCH,
    OP_C_MERGE,
    OP_C_ADV,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e   op;
    outcome_e outcome;
  } dp_cmd_t;

  typedef struct packed {
    logic chain_valid;
    logic fit;
    logic exact;
    logic split_ok;
    logic rd_last;
    logic addr_hit;
    logic scan_free;
    logic scan_last;
    logic a_last;
    logic both_free;
  } dp_status_t;

endpackage

// ===== rtl/ffa_dp.sv =====
// Datapath of the allocator: block record memory, slot occupancy bits, walk registers.
// Depends on ffa_pkg; driven by ffa_ctrl through dp_cmd_t.
module ffa_dp import ffa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  req_t        in_data_i,
  input  logic [31:0] region_base_i,
  input  logic [31:0] region_bytes_i,
  input  logic [7:0]  header_bytes_i,
  output dp_status_t  status_o,
  output rsp_t        out_data_o
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef struct packed {
    logic [31:0]     start;
    logic [31:0]     size;
    logic            free;
    logic [IdxW-1:0] link;
  } rec_t;

  rec_t mem [MAX_BLOCKS];
  rec_t rd_q, a_q, wdata;
  logic we, re;
  logic [IdxW-1:0] waddr, raddr;

  logic [IdxW-1:0] cur_q, cur_d, nx_q, nx_d, scan_q, scan_d;
  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;
  logic chain_valid_q, chain_valid_d;
  logic [31:0] req_q, addr_q;
  rec_t a_d;
  rsp_t res_q, res_d, out_q;
  logic [31:0] hdr;
  logic [32:0] req_plus_hdr;

  assign hdr = {24'd0, header_bytes_i};
  assign req_plus_hdr = {1'b0, req_q} + {1'b0, hdr};

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    waddr = cur_q;
    raddr = cur_q;
    wdata = rd_q;
    cur_d = cur_q;
    nx_d = nx_q;
    scan_d = scan_q;
    in_use_d = in_use_q;
    chain_valid_d = chain_valid_q;
    a_d = a_q;
    res_d = res_q;
    unique case (cmd_i.op)
      OP_LATCH, OP_READ_HEAD: begin
        re = 1'b1;
        raddr = '0;
        cur_d = '0;
      end
      OP_SETUP: begin
        we = 1'b1;
        waddr = '0;
        wdata.start = region_base_i;
        wdata.size = (region_bytes_i >= hdr) ? region_bytes_i - hdr : 32'd0;
        wdata.free = 1'b1;
        wdata.link = '0;
        in_use_d = '0;
        in_use_d[0] = 1'b1;
        chain_valid_d = 1'b1;
      end
      OP_NEXT: begin
        re = 1'b1;
        raddr = rd_q.link;
        cur_d = rd_q.link;
      end
      OP_MARK_USED: begin
        we = 1'b1;
        wdata.free = 1'b0;
        res_d.granted_address = rd_q.start + hdr;
        res_d.outcome = OUT_OK;
      end
      OP_SCAN_START: begin
        a_d = rd_q;
        scan_d = '0;
      end
      OP_SCAN_INC: scan_d = scan_q + 1'b1;
      OP_SPLIT_NEW: begin
        we = 1'b1;
        waddr = scan_q;
        wdata.start = a_q.start + hdr + req_q;
        wdata.size = a_q.size - req_q - hdr;
        wdata.free = 1'b1;
        wdata.link = (a_q.link == cur_q) ? scan_q : a_q.link;
        in_use_d[scan_q] = 1'b1;
        nx_d = scan_q;
      end
      OP_SPLIT_CUR: begin
        we = 1'b1;
        wdata.start = a_q.start;
        wdata.size = req_q;
        wdata.free = 1'b0;
        wdata.link = nx_q;
        res_d.granted_address = a_q.start + hdr;
        res_d.outcome = OUT_OK;
      end
      OP_RESULT: begin
        res_d.granted_address = '0;
        res_d.outcome = cmd_i.outcome;
      end
      OP_MARK_FREE: begin
        we = 1'b1;
        wdata.free = 1'b1;
      end
      OP_C_LOAD: a_d = rd_q;
      OP_C_FETCH: begin
        re = 1'b1;
        raddr = a_q.link;
        nx_d = a_q.link;
      end
      OP_C_MERGE: begin
        a_d.size = a_q.size + rd_q.size + hdr;
        a_d.link = (rd_q.link == nx_q) ? cur_q : rd_q.link;
        we = 1'b1;
        wdata = a_d;
        in_use_d[nx_q] = 1'b0;
      end
      OP_C_ADV: begin
        a_d = rd_q;
        cur_d = nx_q;
      end
      OP_NONE, OP_LOAD_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nx_q <= nx_d;
    scan_q <= scan_d;
    a_q <= a_d;
    res_q <= res_d;
    if (cmd_i.op == OP_LATCH) begin
      req_q <= in_data_i.request_bytes;
      addr_q <= in_data_i.release_address;
    end
    if (cmd_i.op == OP_LOAD_OUT) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      chain_valid_q <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
      chain_valid_q <= chain_valid_d;
    end
  end

  always_comb begin
    status_o.chain_valid = chain_valid_q;
    status_o.fit = rd_q.free && (rd_q.size >= req_q);
    status_o.exact = rd_q.size == req_q;
    status_o.split_ok = {1'b0, rd_q.size} > req_plus_hdr;
    status_o.rd_last = rd_q.link == cur_q;
    status_o.addr_hit = (rd_q.start + hdr) == addr_q;
    status_o.scan_free = !in_use_q[scan_q];
    status_o.scan_last = scan_q == IdxW'(MAX_BLOCKS - 1);
    status_o.a_last = a_q.link == cur_q;
    status_o.both_free = a_q.free && rd_q.free;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/ffa_ctrl.sv =====
// Sequencer of the allocator: walks the chain, splits, coalesces and hands out results.
// Depends on ffa_pkg; commands ffa_dp through dp_cmd_t.
module ffa_ctrl import ffa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_A_RD, S_A_CHK, S_SCAN, S_SPLIT,
    S_R_CHK, S_C_HEAD, S_C_LOAD, S_C_M, S_C_B, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op = OP_NONE;
    cmd_o.outcome = OUT_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          if (in_kind_i == KIND_RELEASE) begin
            state_d = S_R_CHK;
          end else if (status_i.chain_valid) begin
            state_d = S_A_CHK;
          end else begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o.op = OP_SETUP;
        state_d = S_A_RD;
      end
      S_A_RD: begin
        cmd_o.op = OP_READ_HEAD;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (status_i.fit) begin
          if (status_i.exact) begin
            cmd_o.op = OP_MARK_USED;
            state_d = S_FIN;
          end else if (status_i.split_ok) begin
            cmd_o.op = OP_SCAN_START;
            state_d = S_SCAN;
          end else begin
            cmd_o.op = OP_RESULT;
            cmd_o.outcome = OUT_NO_FIT;
            state_d = S_FIN;
          end
        end else if (status_i.rd_last) begin
          cmd_o.op = OP_RESULT;
          cmd_o.outcome = OUT_NO_FIT;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_NEXT;
        end
      end
      S_SCAN: begin
        if (status_i.scan_free) begin
          cmd_o.op = OP_SPLIT_NEW;
          state_d = S_SPLIT;
        end else if (status_i.scan_last) begin
          cmd_o.op = OP_RESULT;
          cmd_o.outcome = OUT_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_SCAN_INC;
        end
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT_CUR;
        state_d = S_FIN;
      end
      S_R_CHK: begin
        if (!status_i.chain_valid || (!status_i.addr_hit && status_i.rd_last)) begin
          cmd_o.op = OP_RESULT;
          cmd_o.outcome = OUT_BAD_ADDR;
          state_d = S_FIN;
        end else if (status_i.addr_hit) begin
          cmd_o.op = OP_MARK_FREE;
          state_d = S_C_HEAD;
        end else begin
          cmd_o.op = OP_NEXT;
        end
      end
      S_C_HEAD: begin
        cmd_o.op = OP_READ_HEAD;
        state_d = S_C_LOAD;
      end
      S_C_LOAD: begin
        cmd_o.op = OP_C_LOAD;
        state_d = S_C_M;
      end
      S_C_M: begin
        if (status_i.a_last) begin
          cmd_o.op = OP_RESULT;
          cmd_o.outcome = OUT_OK;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_C_FETCH;
          state_d = S_C_B;
        end
      end
      S_C_B: begin
        cmd_o.op = status_i.both_free ? OP_C_MERGE : OP_C_ADV;
        state_d = S_C_M;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// First-fit block allocator top level: APB register file, sequencer and datapath.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
//
// Requests arrive on the input channel (valid/stall) as req_t: kind 0 allocates
// request_bytes, kind 1 releases the block whose data address is release_address.
// Each request gives exactly one rsp_t transfer on the output channel.
// One request is processed at a time; the input is stalled while it runs.
// An allocate walks the block chain one slot per cycle; a split adds a scan
// for a spare slot, one slot per cycle, and two record writes. A release
// walks the chain the same way, then coalesces with one pass over the chain,
// stepping through S_C_M and S_C_B for each block visited.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, the next result waits until that register is free.
// After reset the chain is empty; the first allocate builds it from the
// region registers. The user must write the registers over the APB port only
// while idle; the block itself does not enforce it.
module first_fit_block_allocator_unit import ffa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] region_base_q, region_bytes_q;
  logic [7:0]  header_bytes_q;
  logic [1:0]  reg_idx;
  logic        cfg_we;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= REGION_BASE_RST;
      region_bytes_q <= REGION_BYTES_RST;
      header_bytes_q <= HEADER_BYTES_RST;
    end else if (cfg_we) begin
      if (reg_idx == REG_REGION_BASE) begin
        region_base_q <= pwdata;
      end
      if (reg_idx == REG_REGION_BYTES) begin
        region_bytes_q <= pwdata;
      end
      if (reg_idx == REG_HEADER_BYTES) begin
        header_bytes_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_REGION_BASE) begin
      prdata = region_base_q;
    end else if (reg_idx == REG_REGION_BYTES) begin
      prdata = region_bytes_q;
    end else if (reg_idx == REG_HEADER_BYTES) begin
      prdata = {24'd0, header_bytes_q};
    end
  end

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ffa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_data_i      (in_data_i),
    .region_base_i  (region_base_q),
    .region_bytes_i (region_bytes_q),
    .header_bytes_i (header_bytes_q),
    .status_o       (status),
    .out_data_o     (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_fail_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.outcome != OUT_OK) |-> out_data_o.granted_address == '0)
    else $error("failed request carries an address");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in progress");

endmodule
